/* sv/bfg_pkg.sv */
// ----------------------------------------------------------------------------
// bfg_pkg
// Shared widths, register indexes, charge tables and control structures of
// the battery fuel gauge.
// ----------------------------------------------------------------------------
package bfg_pkg;

   localparam int ADC_BITS    = 12;
   localparam int CFG_W       = 8;
   localparam int KEY_W       = 16;
   localparam int IV_W        = 8;
   localparam int BATT_W      = 16;
   localparam int CAP_W       = 7;
   localparam int CNT_W       = 8;
   localparam int PROD_W      = ADC_BITS + CFG_W;
   localparam int STEP_W      = $clog2(PROD_W);
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 16;

   localparam int TABLE_STEPS = 10;
   localparam int TBL_SLOTS   = 16;
   localparam int LEVEL_FULL  = 100;
   localparam int LEVEL_STEP  = 10;
   localparam int LEVEL_COUNT = 10;

   localparam logic [CSR_ADDR_W-1:0] REG_INPUT_SCALE       = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INPUT_OFFSET      = 4'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BATT_SCALE        = 4'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_CONNECT_THRESHOLD = 4'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SWITCH_DELAY      = 4'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_CONFIRM_COUNT     = 4'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_TICKS_PER_UPDATE  = 4'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY_MIN_VOLTAGE   = 4'd7;

   localparam logic [CFG_W-1:0] RST_INPUT_SCALE       = 8'd72;
   localparam logic [CFG_W-1:0] RST_INPUT_OFFSET      = 8'd8;
   localparam logic [CFG_W-1:0] RST_BATT_SCALE        = 8'd122;
   localparam logic [CFG_W-1:0] RST_CONNECT_THRESHOLD = 8'd90;
   localparam logic [CFG_W-1:0] RST_SWITCH_DELAY      = 8'd30;
   localparam logic [CFG_W-1:0] RST_CONFIRM_COUNT     = 8'd5;
   localparam logic [CFG_W-1:0] RST_TICKS_PER_UPDATE  = 8'd100;
   localparam logic [KEY_W-1:0] RST_KEY_MIN_VOLTAGE   = 16'd300;

   localparam logic [BATT_W-1:0] CHARGE_TBL [TBL_SLOTS] = '{
      16'd420, 16'd415, 16'd410, 16'd400, 16'd395, 16'd385, 16'd375, 16'd365,
      16'd355, 16'd345, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
   };
   localparam logic [BATT_W-1:0] DISCHARGE_TBL [TBL_SLOTS] = '{
      16'd400, 16'd390, 16'd380, 16'd370, 16'd360, 16'd350, 16'd340, 16'd330,
      16'd320, 16'd310, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
   };

   typedef struct packed {
      logic [CFG_W-1:0] input_scale;
      logic [CFG_W-1:0] input_offset;
      logic [CFG_W-1:0] batt_scale;
      logic [CFG_W-1:0] connect_threshold;
      logic [CFG_W-1:0] switch_delay_seconds;
      logic [CFG_W-1:0] confirm_count;
      logic [CFG_W-1:0] ticks_per_update;
      logic [KEY_W-1:0] key_min_voltage;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic key_press;
      logic mul_load;
      logic mul_batt;
      logic div_step;
      logic fin_in;
      logic fin_bat;
      logic cap_upd;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic update_due;
   } stat_type;

   // first entry the voltage exceeds sets the level; none gives empty
   function automatic logic [CAP_W-1:0] table_level(input logic [BATT_W-1:0] v,
                                                    input logic charge);
      logic [CAP_W-1:0] lvl;
      logic [BATT_W-1:0] entry;
      lvl = '0;
      for (int i = TABLE_STEPS - 1; i >= 0; i--) begin
         entry = charge ? CHARGE_TBL[i] : DISCHARGE_TBL[i];
         if (v > entry) begin
            lvl = (i < LEVEL_COUNT) ? CAP_W'(LEVEL_FULL - LEVEL_STEP * i) : '0;
         end
      end
      return lvl;
   endfunction

endpackage

/* sv/bfg_req_if.sv */
// ----------------------------------------------------------------------------
// bfg_req_if
// Request channel: tick samples or key press.
// ----------------------------------------------------------------------------
interface bfg_req_if import bfg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [ADC_BITS-1:0] adc_input;
   logic [ADC_BITS-1:0] adc_ref;
   logic [ADC_BITS-1:0] adc_batt;

   modport source (output valid, req_type, adc_input, adc_ref, adc_batt, input ready);
   modport sink   (input valid, req_type, adc_input, adc_ref, adc_batt, output ready);
endinterface

/* sv/bfg_rsp_if.sv */
// ----------------------------------------------------------------------------
// bfg_rsp_if
// Response channel: gauge state after each request.
// ----------------------------------------------------------------------------
interface bfg_rsp_if import bfg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CAP_W-1:0]  capacity_percent;
   logic [IV_W-1:0]   input_voltage;
   logic [BATT_W-1:0] battery_voltage;
   logic              power_connected;
   logic              key_drive;

   modport source (output valid, capacity_percent, input_voltage, battery_voltage,
                   power_connected, key_drive, input ready);
   modport sink   (input valid, capacity_percent, input_voltage, battery_voltage,
                   power_connected, key_drive, output ready);
endinterface

/* sv/bfg_csr_if.sv */
// ----------------------------------------------------------------------------
// bfg_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface bfg_csr_if import bfg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

/* sv/bfg_csr.sv */
// ----------------------------------------------------------------------------
// bfg_csr
// Configuration registers with their reset values.
// ----------------------------------------------------------------------------
module bfg_csr import bfg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   output logic                  wr_ready,
   input  logic [CSR_ADDR_W-1:0] wr_addr,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_addr)
            REG_INPUT_SCALE:       cfg_in.input_scale          = wr_data[CFG_W-1:0];
            REG_INPUT_OFFSET:      cfg_in.input_offset         = wr_data[CFG_W-1:0];
            REG_BATT_SCALE:        cfg_in.batt_scale           = wr_data[CFG_W-1:0];
            REG_CONNECT_THRESHOLD: cfg_in.connect_threshold    = wr_data[CFG_W-1:0];
            REG_SWITCH_DELAY:      cfg_in.switch_delay_seconds = wr_data[CFG_W-1:0];
            REG_CONFIRM_COUNT:     cfg_in.confirm_count        = wr_data[CFG_W-1:0];
            REG_TICKS_PER_UPDATE:  cfg_in.ticks_per_update     = wr_data[CFG_W-1:0];
            REG_KEY_MIN_VOLTAGE:   cfg_in.key_min_voltage      = wr_data[KEY_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_scale          <= RST_INPUT_SCALE;
         cfg_ff.input_offset         <= RST_INPUT_OFFSET;
         cfg_ff.batt_scale           <= RST_BATT_SCALE;
         cfg_ff.connect_threshold    <= RST_CONNECT_THRESHOLD;
         cfg_ff.switch_delay_seconds <= RST_SWITCH_DELAY;
         cfg_ff.confirm_count        <= RST_CONFIRM_COUNT;
         cfg_ff.ticks_per_update     <= RST_TICKS_PER_UPDATE;
         cfg_ff.key_min_voltage      <= RST_KEY_MIN_VOLTAGE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/bfg_dpath.sv */
// ----------------------------------------------------------------------------
// bfg_dpath
// Gauge datapath: sample latch, multiplier, shared restoring divider,
// gauge state and response register.
// ----------------------------------------------------------------------------
module bfg_dpath import bfg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [ADC_BITS-1:0] adc_input,
   input  logic [ADC_BITS-1:0] adc_ref,
   input  logic [ADC_BITS-1:0] adc_batt,
   output logic [CAP_W-1:0]    capacity_percent,
   output logic [IV_W-1:0]     input_voltage,
   output logic [BATT_W-1:0]   battery_voltage,
   output logic                power_connected,
   output logic                key_drive
);

   logic [ADC_BITS-1:0] ain_ff, aref_ff, abat_ff;
   logic [ADC_BITS-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [BATT_W-1:0] batt_ff, batt_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [IV_W-1:0]   iv_ff, iv_in;
   logic [CNT_W-1:0]  tick_ff, tick_in;
   logic [CNT_W-1:0]  delay_ff, delay_in;
   logic [CNT_W-1:0]  confirm_ff, confirm_in;
   logic              conn_prev_ff, conn_prev_in;
   logic              key_seen_ff, key_seen_in;
   logic              key_level_ff, key_level_in;

   logic [CAP_W-1:0]  out_cap_ff;
   logic [IV_W-1:0]   out_iv_ff;
   logic [BATT_W-1:0] out_batt_ff;
   logic              out_conn_ff, out_key_ff;

   logic [ADC_BITS:0]   rem_shift;
   logic                rem_ge;
   logic                ref_zero;
   logic [IV_W-1:0]     q_in_sat;
   logic [IV_W-1:0]     iv_new;
   logic                conn_new;
   logic [CNT_W-1:0]    tick_inc;
   logic [CNT_W-1:0]    confirm_inc;
   logic [CNT_W-1:0]    limit;
   logic                conn_now;
   logic [CAP_W-1:0]    lvl;
   logic [CFG_W-1:0]    mul_scale;
   logic [ADC_BITS-1:0] mul_arg;

   assign rem_shift   = {rem_ff, quo_ff[PROD_W-1]};
   assign rem_ge      = rem_shift >= {1'b0, aref_ff};
   assign ref_zero    = (aref_ff == '0);
   assign q_in_sat    = ref_zero ? '1 : quo_ff[IV_W-1:0];
   assign iv_new      = q_in_sat + cfg.input_offset;
   assign conn_new    = iv_new > cfg.connect_threshold;
   assign tick_inc    = tick_ff + CNT_W'(1);
   assign confirm_inc = confirm_ff + CNT_W'(1);
   assign conn_now    = iv_ff > cfg.connect_threshold;
   assign lvl         = table_level(batt_ff, conn_now);
   assign mul_scale   = cmd.mul_batt ? cfg.batt_scale : cfg.input_scale;
   assign mul_arg     = cmd.mul_batt ? abat_ff : ain_ff;

   assign stat.div_last   = (step_ff == STEP_W'(PROD_W - 1));
   assign stat.update_due = tick_inc > cfg.ticks_per_update;

   always_comb begin
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      batt_in      = batt_ff;
      cap_in       = cap_ff;
      iv_in        = iv_ff;
      tick_in      = tick_ff;
      delay_in     = delay_ff;
      confirm_in   = confirm_ff;
      conn_prev_in = conn_prev_ff;
      key_seen_in  = key_seen_ff;
      key_level_in = key_level_ff;
      limit        = cfg.confirm_count;

      if (cmd.mul_load) begin
         quo_in  = PROD_W'(mul_arg) * PROD_W'(mul_scale);
         rem_in  = '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         quo_in  = {quo_ff[PROD_W-2:0], rem_ge};
         rem_in  = rem_ge ? ADC_BITS'(rem_shift - {1'b0, aref_ff}) : rem_shift[ADC_BITS-1:0];
         step_in = step_ff + STEP_W'(1);
      end

      if (cmd.key_press && (batt_ff >= cfg.key_min_voltage)) begin
         key_level_in = 1'b1;
         key_seen_in  = 1'b0;
      end

      if (cmd.fin_in) begin
         if (key_level_ff) begin
            if (!key_seen_ff) key_seen_in = 1'b1;
            else              key_level_in = 1'b0;
         end
         iv_in = iv_new;
         if (conn_new != conn_prev_ff) begin
            conn_prev_in = conn_new;
            delay_in     = cfg.switch_delay_seconds;
         end
         tick_in = stat.update_due ? '0 : tick_inc;
      end

      if (cmd.fin_bat) begin
         batt_in = ref_zero ? '1 : quo_ff[BATT_W-1:0];
      end

      // hold the level until enough agreeing updates move it one way
      if (cmd.cap_upd) begin
         if (delay_ff != '0) begin
            delay_in = delay_ff - CNT_W'(1);
         end else if (conn_now) begin
            if (lvl > cap_ff) begin
               confirm_in = confirm_inc;
               if (confirm_inc > cfg.confirm_count) begin
                  confirm_in = '0;
                  cap_in     = lvl;
               end
            end else begin
               confirm_in = '0;
            end
         end else begin
            if (lvl < cap_ff) begin
               limit      = (lvl == '0) ? '0 : cfg.confirm_count;
               confirm_in = confirm_inc;
               if (confirm_inc > limit) begin
                  confirm_in = '0;
                  cap_in     = lvl;
               end
            end else begin
               confirm_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batt_ff      <= '0;
         cap_ff       <= '0;
         iv_ff        <= '0;
         tick_ff      <= '0;
         delay_ff     <= '0;
         confirm_ff   <= '0;
         conn_prev_ff <= 1'b0;
         key_seen_ff  <= 1'b0;
         key_level_ff <= 1'b0;
      end else begin
         batt_ff      <= batt_in;
         cap_ff       <= cap_in;
         iv_ff        <= iv_in;
         tick_ff      <= tick_in;
         delay_ff     <= delay_in;
         confirm_ff   <= confirm_in;
         conn_prev_ff <= conn_prev_in;
         key_seen_ff  <= key_seen_in;
         key_level_ff <= key_level_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (cmd.load) begin
         ain_ff  <= adc_input;
         aref_ff <= adc_ref;
         abat_ff <= adc_batt;
      end
      if (cmd.rsp_load) begin
         out_cap_ff  <= cap_ff;
         out_iv_ff   <= iv_ff;
         out_batt_ff <= batt_ff;
         out_conn_ff <= conn_now;
         out_key_ff  <= key_level_ff;
      end
   end

   assign capacity_percent = out_cap_ff;
   assign input_voltage    = out_iv_ff;
   assign battery_voltage  = out_batt_ff;
   assign power_connected  = out_conn_ff;
   assign key_drive        = out_key_ff;

endmodule

/* sv/bfg_ctrl.sv */
// ----------------------------------------------------------------------------
// bfg_ctrl
// Sequencer: steps the datapath through one request and owns both
// handshakes.
// ----------------------------------------------------------------------------
module bfg_ctrl import bfg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_kind,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_KEY, S_MUL_IN, S_DIV_IN, S_FIN_IN,
      S_MUL_BAT, S_DIV_BAT, S_FIN_BAT, S_CAP, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = req_kind ? S_KEY : S_MUL_IN;
            end
         end
         S_KEY: begin
            cmd.key_press = 1'b1;
            state_in      = S_DONE;
         end
         S_MUL_IN: begin
            cmd.mul_load = 1'b1;
            state_in     = S_DIV_IN;
         end
         S_DIV_IN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_FIN_IN;
         end
         S_FIN_IN: begin
            cmd.fin_in = 1'b1;
            state_in   = stat.update_due ? S_MUL_BAT : S_DONE;
         end
         S_MUL_BAT: begin
            cmd.mul_load = 1'b1;
            cmd.mul_batt = 1'b1;
            state_in     = S_DIV_BAT;
         end
         S_DIV_BAT: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_FIN_BAT;
         end
         S_FIN_BAT: begin
            cmd.fin_bat = 1'b1;
            state_in    = S_CAP;
         end
         S_CAP: begin
            cmd.cap_upd = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready)   rsp_valid_ff <= 1'b0;
      end
   end

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overwritten before delivery");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.rsp_load))
      else $error("response raised without a load");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.key_press, cmd.mul_load, cmd.div_step, cmd.fin_in,
                cmd.fin_bat, cmd.cap_upd, cmd.rsp_load}))
      else $error("conflicting datapath commands");
`endif

endmodule

/* sv/battery_fuel_gauge_hysteresis_top.sv */
// ----------------------------------------------------------------------------
// battery_fuel_gauge_hysteresis_top
// Voltage-based battery capacity gauge with charge/discharge hysteresis.
// ----------------------------------------------------------------------------
// Key press request: states KEY and DONE lie between acceptance and response.
// Tick: MUL_IN, DIV_IN, FIN_IN, then on a capacity update MUL_BAT, DIV_BAT,
// FIN_BAT and CAP, then DONE; both voltage scalings share the 20-step restoring divider.
// One request in flight; the next is taken while the response waits.
// Synchronous active-high reset clears gauge state and loads register defaults.
// ----------------------------------------------------------------------------
module battery_fuel_gauge_hysteresis_top import bfg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bfg_req_if.sink    req_ch,
   bfg_rsp_if.source  rsp_ch,
   bfg_csr_if.sink    csr_ch
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   bfg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_ready (csr_ch.ready),
      .wr_addr  (csr_ch.addr),
      .wr_data  (csr_ch.wdata),
      .cfg      (cfg)
   );

   bfg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_kind  (req_ch.req_type),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfg_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .stat             (stat),
      .adc_input        (req_ch.adc_input),
      .adc_ref          (req_ch.adc_ref),
      .adc_batt         (req_ch.adc_batt),
      .capacity_percent (rsp_ch.capacity_percent),
      .input_voltage    (rsp_ch.input_voltage),
      .battery_voltage  (rsp_ch.battery_voltage),
      .power_connected  (rsp_ch.power_connected),
      .key_drive        (rsp_ch.key_drive)
   );

endmodule

/* dv/bfg_gauge_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfg_gauge_checker
// Watches the request, response and register channels of the fuel gauge,
// keeps its own copy of the register settings and gauge state, predicts the
// reading that each accepted request produces and compares every accepted
// response with the oldest predicted reading.
// ----------------------------------------------------------------------------
module bfg_gauge_checker import bfg_pkg::*; (
   input  logic clock,
   input  logic reset,
   bfg_req_if   req_ch,
   bfg_rsp_if   rsp_ch,
   bfg_csr_if   csr_ch,
   output int   mismatch_count,
   output int   readings_due
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [CAP_W-1:0]  capacity_percent;
      logic [IV_W-1:0]   input_voltage;
      logic [BATT_W-1:0] battery_voltage;
      logic              power_connected;
      logic              key_drive;
   } gauge_reading_type;

   cfg_type           gauge_cfg;
   logic [BATT_W-1:0] batt_v;
   logic [CAP_W-1:0]  capacity;
   logic [IV_W-1:0]   input_v;
   logic [CNT_W-1:0]  tick_count;
   logic [CNT_W-1:0]  settle_count;
   logic [CNT_W-1:0]  confirm_run;
   logic              mains_prev;
   logic              key_armed;
   logic              key_level;
   gauge_reading_type readings_expected [$];
   int                fault_total = 0;

   assign mismatch_count = fault_total;

   function automatic logic [CAP_W-1:0] table_step_level(input logic [BATT_W-1:0] v,
                                                          input logic charging);
      logic [BATT_W-1:0] entry;
      int                step;
      step = TABLE_STEPS;
      for (int i = 0; i < TABLE_STEPS; i++) begin
         entry = charging ? CHARGE_TBL[i] : DISCHARGE_TBL[i];
         if (step == TABLE_STEPS && v > entry) step = i;
      end
      return (step >= LEVEL_COUNT) ? '0 : CAP_W'(LEVEL_FULL - LEVEL_STEP * step);
   endfunction

   function automatic void settle_capacity();
      logic             charging;
      logic [CAP_W-1:0] level;
      logic [CNT_W-1:0] needed;
      if (settle_count != '0) begin
         settle_count = settle_count - 1'b1;
      end else begin
         charging = input_v > gauge_cfg.connect_threshold;
         level    = table_step_level(batt_v, charging);
         if (charging ? (level > capacity) : (level < capacity)) begin
            // an empty battery is taken at once
            needed      = (!charging && level == '0) ? '0 : gauge_cfg.confirm_count;
            confirm_run = confirm_run + 1'b1;
            if (confirm_run > needed) begin
               confirm_run = '0;
               capacity    = level;
            end
         end else begin
            confirm_run = '0;
         end
      end
   endfunction

   function automatic void advance_tick(input logic [ADC_BITS-1:0] ain,
                                        input logic [ADC_BITS-1:0] aref,
                                        input logic [ADC_BITS-1:0] abat);
      logic [PROD_W-1:0] product;
      logic [PROD_W-1:0] quotient;
      if (key_level) begin
         if (!key_armed) key_armed = 1'b1;
         else key_level = 1'b0;
      end
      product  = ain * gauge_cfg.input_scale;
      quotient = (aref == '0) ? PROD_W'(8'hFF) : product / aref;
      input_v  = quotient[IV_W-1:0] + gauge_cfg.input_offset;
      if ((input_v > gauge_cfg.connect_threshold) != mains_prev) begin
         mains_prev   = ~mains_prev;
         settle_count = gauge_cfg.switch_delay_seconds;
      end
      tick_count = tick_count + 1'b1;
      if (tick_count > gauge_cfg.ticks_per_update) begin
         tick_count = '0;
         product    = abat * gauge_cfg.batt_scale;
         batt_v     = (aref == '0) ? '1 : BATT_W'(product / aref);
         settle_capacity();
      end
   endfunction

   function automatic void press_key();
      if (batt_v >= gauge_cfg.key_min_voltage) begin
         key_level = 1'b1;
         key_armed = 1'b0;
      end
   endfunction

   function automatic void apply_register(input logic [CSR_ADDR_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_INPUT_SCALE:       gauge_cfg.input_scale          = value[CFG_W-1:0];
         REG_INPUT_OFFSET:      gauge_cfg.input_offset         = value[CFG_W-1:0];
         REG_BATT_SCALE:        gauge_cfg.batt_scale           = value[CFG_W-1:0];
         REG_CONNECT_THRESHOLD: gauge_cfg.connect_threshold    = value[CFG_W-1:0];
         REG_SWITCH_DELAY:      gauge_cfg.switch_delay_seconds = value[CFG_W-1:0];
         REG_CONFIRM_COUNT:     gauge_cfg.confirm_count        = value[CFG_W-1:0];
         REG_TICKS_PER_UPDATE:  gauge_cfg.ticks_per_update     = value[CFG_W-1:0];
         REG_KEY_MIN_VOLTAGE:   gauge_cfg.key_min_voltage      = value[KEY_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic gauge_reading_type current_reading();
      return {capacity, input_v, batt_v, input_v > gauge_cfg.connect_threshold, key_level};
   endfunction

   always @(posedge clock) begin : watch
      gauge_reading_type seen;
      gauge_reading_type want;
      if (reset) begin
         gauge_cfg    = '{RST_INPUT_SCALE, RST_INPUT_OFFSET, RST_BATT_SCALE,
                          RST_CONNECT_THRESHOLD, RST_SWITCH_DELAY, RST_CONFIRM_COUNT,
                          RST_TICKS_PER_UPDATE, RST_KEY_MIN_VOLTAGE};
         batt_v       = '0;
         capacity     = '0;
         input_v      = '0;
         tick_count   = '0;
         settle_count = '0;
         confirm_run  = '0;
         mains_prev   = 1'b0;
         key_armed    = 1'b0;
         key_level    = 1'b0;
         readings_expected.delete();
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen = {rsp_ch.capacity_percent, rsp_ch.input_voltage, rsp_ch.battery_voltage,
                    rsp_ch.power_connected, rsp_ch.key_drive};
            if (readings_expected.size() == 0) begin
               fault_total++;
               if (fault_total <= MAX_REPORTS)
                  $display("%0t: response with no request outstanding: %p", $realtime, seen);
            end else begin
               want = readings_expected.pop_front();
               if (seen !== want) begin
                  fault_total++;
                  if (fault_total <= MAX_REPORTS)
                     $display({"%0t: response mismatch: expected cap %0d in %0d batt %0d ",
                               "conn %0b key %0b, got cap %0d in %0d batt %0d conn %0b key %0b"},
                              $realtime, want.capacity_percent, want.input_voltage,
                              want.battery_voltage, want.power_connected, want.key_drive,
                              seen.capacity_percent, seen.input_voltage,
                              seen.battery_voltage, seen.power_connected, seen.key_drive);
               end
            end
         end
         if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)
            apply_register(csr_ch.addr, csr_ch.wdata);
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            if (req_ch.req_type) press_key();
            else advance_tick(req_ch.adc_input, req_ch.adc_ref, req_ch.adc_batt);
            readings_expected.push_back(current_reading());
         end
      end
      readings_due <= readings_expected.size();
   end

endmodule

/* dv/battery_fuel_gauge_hysteresis_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_fuel_gauge_hysteresis_top_tb
// Drives tick and key press requests into the fuel gauge under a series of
// register settings, from directed corner cases to long runs of plausible
// charge and discharge sequences mixed with raw noise, with random idling on
// both channels and one long response hold-off. The checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------
module battery_fuel_gauge_hysteresis_top_tb;
   import bfg_pkg::*;

   localparam logic REQ_TICK      = 1'b0;
   localparam logic REQ_KEY_PRESS = 1'b1;
   localparam int   CYCLE_LIMIT   = 600_000;
   localparam int   HOLD_CYCLES   = 400;
   localparam int   TAIL_CYCLES   = 60;
   localparam int   PHASE_COUNT   = 10;
   localparam int   PHASE_ITEMS   = 173;

   logic clock;
   logic reset;
   int   gap_pct       = 0;
   int   stall_pct     = 0;
   bit   hold_rsp      = 1'b0;
   bit   on_mains      = 1'b0;
   int   scenario_left = 0;
   int   batt_walk     = 3000;
   int   cycle_count   = 0;
   int   mismatch_count;
   int   readings_due;

   bfg_req_if req_ch ();
   bfg_rsp_if rsp_ch ();
   bfg_csr_if csr_ch ();

   battery_fuel_gauge_hysteresis_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bfg_gauge_checker gauge_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .readings_due   (readings_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic offer_request(input logic kind, input logic [ADC_BITS-1:0] ain,
                                input logic [ADC_BITS-1:0] aref,
                                input logic [ADC_BITS-1:0] abat);
      int gap;
      gap = (gap_pct > 0 && $urandom_range(99) < gap_pct) ? $urandom_range(7, 1) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= kind;
      req_ch.adc_input <= ain;
      req_ch.adc_ref   <= aref;
      req_ch.adc_batt  <= abat;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic drain_readings();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (readings_due != 0);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= index;
      csr_ch.wdata <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
   endtask

   task automatic program_gauge(input cfg_type setting);
      write_register(REG_INPUT_SCALE,       {8'($urandom), setting.input_scale});
      write_register(REG_INPUT_OFFSET,      {8'($urandom), setting.input_offset});
      write_register(REG_BATT_SCALE,        {8'($urandom), setting.batt_scale});
      write_register(REG_CONNECT_THRESHOLD, {8'($urandom), setting.connect_threshold});
      write_register(REG_SWITCH_DELAY,      {8'($urandom), setting.switch_delay_seconds});
      write_register(REG_CONFIRM_COUNT,     {8'($urandom), setting.confirm_count});
      write_register(REG_TICKS_PER_UPDATE,  {8'($urandom), setting.ticks_per_update});
      write_register(REG_KEY_MIN_VOLTAGE,   setting.key_min_voltage);
      // unmapped index, must leave every register alone
      write_register(CSR_ADDR_W'($urandom_range(2 ** CSR_ADDR_W - 1, REG_KEY_MIN_VOLTAGE + 1)),
                     CSR_DATA_W'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_request();
      int roll;
      if (scenario_left == 0) begin
         on_mains      = 1'($urandom_range(1));
         scenario_left = $urandom_range(60, 15);
      end
      scenario_left--;
      // drift the battery up on mains, down without
      batt_walk += on_mains ? int'($urandom_range(60)) - 20 : int'($urandom_range(60)) - 40;
      if (batt_walk < 2200) batt_walk = 2200;
      if (batt_walk > 3700) batt_walk = 3700;
      roll = $urandom_range(99);
      if (roll < 12)
         offer_request(logic'($urandom_range(1)), ADC_BITS'($urandom),
                       ($urandom_range(3) == 0) ? '0 : ADC_BITS'($urandom),
                       ADC_BITS'($urandom));
      else if (roll < 22)
         offer_request(REQ_KEY_PRESS, ADC_BITS'($urandom), ADC_BITS'($urandom),
                       ADC_BITS'($urandom));
      else
         offer_request(REQ_TICK,
                       on_mains ? ADC_BITS'($urandom_range(4095, 1600))
                                : ADC_BITS'($urandom_range(1000)),
                       ADC_BITS'($urandom_range(1100, 900)), ADC_BITS'(batt_walk));
   endtask

   initial begin : response_pacing
      int stall_left;
      int held;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            for (held = 1; held < HOLD_CYCLES; held++) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(6, 0);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("battery_fuel_gauge_hysteresis_top_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      cfg_type setting;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= REQ_TICK;
      req_ch.adc_input <= '0;
      req_ch.adc_ref   <= '0;
      req_ch.adc_batt  <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.addr      <= '0;
      csr_ch.wdata     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: key ignored on a flat battery, zero reference saturates
      offer_request(REQ_KEY_PRESS, '1, '1, '1);
      offer_request(REQ_TICK, '0, '0, '0);
      offer_request(REQ_TICK, '1, '1, '1);
      offer_request(REQ_TICK, '1, 12'd1, '1);
      offer_request(REQ_TICK, '0, '1, '0);
      drain_readings();

      // widest scaling, update every other tick, key always allowed
      setting                      = '1;
      setting.connect_threshold    = '0;
      setting.switch_delay_seconds = '0;
      setting.confirm_count        = '0;
      setting.ticks_per_update     = 8'd1;
      setting.key_min_voltage      = '0;
      program_gauge(setting);
      offer_request(REQ_TICK, '1, 12'd1, '1);
      offer_request(REQ_TICK, '1, 12'd1, '1);
      offer_request(REQ_TICK, '0, '0, '0);
      offer_request(REQ_TICK, '0, '0, '1);
      offer_request(REQ_KEY_PRESS, '0, '0, '0);
      offer_request(REQ_TICK, 12'd1234, 12'd2345, 12'd3456);
      offer_request(REQ_TICK, 12'd4000, 12'd100, 12'd50);
      offer_request(REQ_TICK, 12'd7, 12'd4095, 12'd4095);
      offer_request(REQ_KEY_PRESS, '1, '0, '1);
      offer_request(REQ_KEY_PRESS, '0, '1, '0);
      drain_readings();

      // charge to full on mains, then unplug on a flat battery
      setting = '{8'd72, 8'd8, 8'd122, 8'd90, 8'd1, 8'd1, 8'd1, 16'd350};
      program_gauge(setting);
      repeat (6) offer_request(REQ_TICK, 12'd2000, 12'd1000, 12'd3500);
      repeat (4) offer_request(REQ_TICK, 12'd500, 12'd1000, 12'd2400);
      offer_request(REQ_KEY_PRESS, '0, '0, '0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_readings();
         if (phase == 0) begin
            setting = '{RST_INPUT_SCALE, RST_INPUT_OFFSET, RST_BATT_SCALE,
                        RST_CONNECT_THRESHOLD, RST_SWITCH_DELAY, RST_CONFIRM_COUNT,
                        RST_TICKS_PER_UPDATE, RST_KEY_MIN_VOLTAGE};
         end else if (phase == 1) begin
            setting = '1;
         end else if (phase == 2) begin
            setting                  = '0;
            setting.ticks_per_update = 8'd1;
         end else begin
            setting.input_scale          = 8'($urandom_range(90, 60));
            setting.input_offset         = 8'($urandom_range(20));
            setting.batt_scale           = 8'($urandom_range(135, 110));
            setting.connect_threshold    = 8'($urandom_range(100, 80));
            setting.switch_delay_seconds = 8'($urandom_range(4));
            setting.confirm_count        = 8'($urandom_range(4));
            setting.ticks_per_update     = 8'($urandom_range(4, 1));
            setting.key_min_voltage      = 16'($urandom_range(420, 280));
         end
         program_gauge(setting);
         if (phase == PHASE_COUNT - 1 || phase % 3 == 2) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = $urandom_range(40, 10);
            stall_pct = $urandom_range(40, 10);
         end
         if (phase == 3) hold_rsp = 1'b1;
         repeat (PHASE_ITEMS) random_request();
      end

      drain_readings();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && readings_due == 0)
         $display("battery_fuel_gauge_hysteresis_top_tb OK");
      else
         $display("battery_fuel_gauge_hysteresis_top_tb NOT OK");
      $finish;
   end

endmodule
